### rtl/dsa_pkg.sv
// Package for the descriptor slot allocator.
// Holds the item types, configuration register codes, widths and reset values.
// No dependencies.
package dsa_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned INDEX_W       = 10;
    localparam int unsigned SLOT_COUNT_W  = 11;
    localparam int unsigned STRIDE_W      = 9;
    localparam int unsigned ADDR_W        = 64;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned OFFSET_W      = SLOT_COUNT_W + STRIDE_W;

    // Default stack depth.
    localparam int unsigned MAX_SLOTS_DEF = 1024;

    // Configuration reset values.
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = SLOT_COUNT_W'(1024);
    localparam logic [STRIDE_W-1:0]     STRIDE_RST     = STRIDE_W'(32);

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT = 2'd0,
        CFG_SLOT_STRIDE = 2'd1,
        CFG_CPU_BASE = 2'd2,
        CFG_GPU_BASE = 2'd3
    } t_cfg_idx;

    // Request item.
    typedef struct packed {
        logic               req_type;
        logic [INDEX_W-1:0] release_index;
    } t_req;

    // Result item.
    typedef struct packed {
        logic               success;
        logic [INDEX_W-1:0] slot_index;
        logic [ADDR_W-1:0]  cpu_address;
        logic [ADDR_W-1:0]  gpu_address;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;      // accept a free request and push its index
        logic pop;       // accept an allocation and read the stack top
        logic fresh;     // accept an allocation served by the bump counter
        logic load_pop;  // capture the popped index
        logic mul;       // form index times stride
        logic emit;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stack_empty;
        logic out_free;
    } t_sts;

endpackage

### rtl/dsa_ctrl.sv
// Controller for the descriptor slot allocator.
// Sequences one item through accept, stack read (stack allocations only), multiply and output load.
// Depends on dsa_pkg.
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_type,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_MUL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // An item enters only while nothing is in flight.
    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    // Commands decoded from the state and the incoming request.
    always_comb begin
        o_cmd          = '0;
        o_cmd.push     = w_accept && (i_req_type == REQ_FREE);
        o_cmd.pop      = w_accept && (i_req_type == REQ_ALLOC) && !i_sts.stack_empty;
        o_cmd.fresh    = w_accept && (i_req_type == REQ_ALLOC) && i_sts.stack_empty;
        o_cmd.load_pop = (r_state == S_POP);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.emit     = (r_state == S_EMIT) && i_sts.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.pop) begin
                    n_state = S_POP;
                end else if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_POP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/dsa_dp.sv
// Datapath for the descriptor slot allocator.
// Holds the configuration, free stack memory, counters, address arithmetic and output register.
// Depends on dsa_pkg.
module dsa_dp
    import dsa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [INDEX_W-1:0]    i_release_index,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);

    localparam int unsigned STACK_AW = $clog2(MAX_SLOTS);
    localparam int unsigned FILL_W   = $clog2(MAX_SLOTS + 1);
    localparam bit          CLAMP    = (MAX_SLOTS < (2 ** SLOT_COUNT_W));
    localparam logic [SLOT_COUNT_W-1:0] MAX_LIM =
        CLAMP ? SLOT_COUNT_W'(MAX_SLOTS) : {SLOT_COUNT_W{1'b1}};
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_SLOTS);

    // Configuration registers.
    logic [SLOT_COUNT_W-1:0] r_slot_count;
    logic [STRIDE_W-1:0]     r_slot_stride;
    logic [ADDR_W-1:0]       r_cpu_base;
    logic [ADDR_W-1:0]       r_gpu_base;

    // Stack and counters.
    logic [INDEX_W-1:0]      r_stack [MAX_SLOTS];
    logic [INDEX_W-1:0]      r_rd_data;
    logic [FILL_W-1:0]       r_fill;
    logic [SLOT_COUNT_W-1:0] r_next_fresh;

    // Working registers for the item in flight.
    logic [SLOT_COUNT_W-1:0] r_idx;
    logic                    r_ok;
    logic                    r_addr_en;
    logic [OFFSET_W-1:0]     r_off;

    // Output register.
    logic                    r_out_valid;
    t_rsp                    r_out;

    logic [SLOT_COUNT_W-1:0] w_lim;
    logic                    w_full;
    logic [FILL_W-1:0]       w_fill_dec;
    logic                    w_fresh_ok;
    logic                    w_pop_ok;
    logic [SLOT_COUNT_W-1:0] w_pop_idx;

    // Effective limit is the slot count clamped to the stack depth.
    assign w_lim      = (r_slot_count > MAX_LIM) ? MAX_LIM : r_slot_count;
    assign w_full     = (r_fill == FILL_FULL);
    assign w_fill_dec = r_fill - FILL_W'(1);
    assign w_fresh_ok = (r_next_fresh < w_lim);
    assign w_pop_idx  = SLOT_COUNT_W'(r_rd_data);
    assign w_pop_ok   = (w_pop_idx < w_lim);

    assign o_sts.stack_empty = (r_fill == '0);
    assign o_sts.out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp             = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count  <= SLOT_COUNT_RST;
            r_slot_stride <= STRIDE_RST;
            r_cpu_base    <= '0;
            r_gpu_base    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SLOT_COUNT:  r_slot_count  <= i_cfg_wdata[SLOT_COUNT_W-1:0];
                CFG_SLOT_STRIDE: r_slot_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_CPU_BASE:    r_cpu_base    <= i_cfg_wdata;
                CFG_GPU_BASE:    r_gpu_base    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Free stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            r_stack[r_fill[STACK_AW-1:0]] <= i_release_index;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_stack[w_fill_dec[STACK_AW-1:0]];
        end
    end

    // Stack fill and bump counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_next_fresh <= '0;
        end else begin
            if (i_cmd.push && !w_full) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.pop) begin
                r_fill <= w_fill_dec;
            end
            if (i_cmd.fresh && w_fresh_ok) begin
                r_next_fresh <= r_next_fresh + SLOT_COUNT_W'(1);
            end
        end
    end

    // Index and outcome of the item in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_idx     <= '0;
            r_ok      <= !w_full;
            r_addr_en <= 1'b0;
        end else if (i_cmd.fresh) begin
            r_idx     <= r_next_fresh;
            r_ok      <= w_fresh_ok;
            r_addr_en <= w_fresh_ok;
        end else if (i_cmd.load_pop) begin
            r_idx     <= w_pop_idx;
            r_ok      <= w_pop_ok;
            r_addr_en <= w_pop_ok;
        end
        if (i_cmd.mul) begin
            r_off <= r_idx * r_slot_stride;
        end
    end

    // Output register; failures and frees carry zero index and addresses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.success <= r_ok;
            if (r_addr_en) begin
                r_out.slot_index  <= r_idx[INDEX_W-1:0];
                r_out.cpu_address <= r_cpu_base + ADDR_W'(r_off);
                r_out.gpu_address <= r_gpu_base + ADDR_W'(r_off);
            end else begin
                r_out.slot_index  <= '0;
                r_out.cpu_address <= '0;
                r_out.gpu_address <= '0;
            end
        end
    end

endmodule

### rtl/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: LIFO free stack with a bump counter.
// Joins the controller and the datapath. Depends on dsa_pkg, dsa_ctrl and dsa_dp.
//
//   Channel   Direction  Handshake                  Payload
//   req       in         i_req_valid / o_req_ready  i_req (t_req)
//   rsp       out        o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//   cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// One item is in flight at a time. A free or a bump-counter allocation passes through
// S_MUL, then S_EMIT loads the output register; an allocation from the stack first
// passes through S_POP, the extra state being the registered read of the stack memory.
// A new item is taken only once the last one has been loaded into the output register.
// A result waiting in the output register does not block the next acceptance;
// only the final load waits for the output register to free up.
// Reset clears the stack fill, bump counter and output valid, and restores the
// configuration reset values.
module descriptor_slot_allocator
    import dsa_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    dsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req.req_type),
        .i_sts       (w_sts),
        .o_req_ready (o_req_ready),
        .o_cmd       (w_cmd)
    );

    // Storage and arithmetic.
    dsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_release_index (i_req.release_index),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .o_rsp           (o_rsp)
    );

endmodule
